FILE: hw/rtl/slfe_pkg.sv
// ----------------------------------------------------------------------------
// slfe_pkg: shared types and constants of the sync/length frame extractor
// Phase and result-kind codes, sync byte, register widths and reset values.
// ----------------------------------------------------------------------------
package slfe_pkg;

    localparam int unsigned LEN_WIDTH_DEFAULT = 13;
    localparam int unsigned MAX_LEN_WIDTH     = 13;
    localparam int unsigned ACC_WIDTH         = 32;

    localparam logic [7:0]               SYNC_BYTE     = 8'h5E;
    localparam logic [MAX_LEN_WIDTH-1:0] MAX_LEN_RESET = 13'd1024;
    localparam logic [1:0]               LAST_LEN_BYTE = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } item_t;

endpackage

FILE: hw/rtl/slfe_byte_if.sv
// ----------------------------------------------------------------------------
// slfe_byte_if: received byte channel
// Valid/ready handshake carrying one stream byte per item.
// ----------------------------------------------------------------------------
interface slfe_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);

endinterface

FILE: hw/rtl/slfe_result_if.sv
// ----------------------------------------------------------------------------
// slfe_result_if: deframer result channel
// Valid/ready handshake carrying kind, payload byte and last flag per item.
// ----------------------------------------------------------------------------
interface slfe_result_if;

    logic              valid;
    logic              ready;
    slfe_pkg::kind_t   out_kind;
    logic [7:0]        out_byte;
    logic              out_last;

    modport source (output valid, output out_kind, output out_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_kind, input out_byte, input out_last,
                    output ready);

endinterface

FILE: hw/rtl/slfe_in_stage.sv
// ----------------------------------------------------------------------------
// slfe_in_stage: input register
// Captures one accepted byte and holds it until the core takes it.
// ----------------------------------------------------------------------------
module slfe_in_stage
(
    input  logic             clk,
    input  logic             rst_n,
    slfe_byte_if.sink        stream,
    input  logic             take,
    output slfe_pkg::item_t  item
);

    logic       valid_reg;
    logic [7:0] data_reg;

    assign stream.ready = !valid_reg || take;
    assign item.valid   = valid_reg;
    assign item.data    = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stream.valid && stream.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            data_reg <= stream.in_byte;
        end
    end

endmodule

FILE: hw/rtl/slfe_core.sv
// ----------------------------------------------------------------------------
// slfe_core: framing state machine and result register
// Hunts the sync pair, gathers the length, checks it and passes the payload.
// ----------------------------------------------------------------------------
module slfe_core
#(
    parameter int unsigned LEN_WIDTH = slfe_pkg::LEN_WIDTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  slfe_pkg::item_t                     item,
    input  logic [slfe_pkg::MAX_LEN_WIDTH-1:0]  max_len,
    output logic                                take,
    slfe_result_if.source                       result
);

    localparam int unsigned AW = slfe_pkg::ACC_WIDTH;
    localparam logic [AW-1:0] CountMax = AW'((64'd1 << LEN_WIDTH) - 64'd1);

    slfe_pkg::phase_t     phase_reg, phase_next;
    logic [AW-1:0]        acc_reg, acc_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic [LEN_WIDTH-1:0] left_reg, left_next;

    logic                 res_valid_reg;
    slfe_pkg::kind_t      res_kind_reg;
    logic [7:0]           res_byte_reg;
    logic                 res_last_reg;

    logic                 emit;
    slfe_pkg::kind_t      kind;
    logic [7:0]           obyte;
    logic                 olast;
    logic [AW-1:0]        acc_new;
    logic [AW-1:0]        max32;
    logic [AW-1:0]        limit;
    logic [LEN_WIDTH-1:0] left_dec;

    assign take     = item.valid && (!res_valid_reg || result.ready);
    assign max32    = AW'(max_len);
    assign limit    = (max32 > CountMax) ? CountMax : max32;
    assign acc_new  = acc_reg | (AW'(item.data) << {cnt_reg, 3'b000});
    assign left_dec = (left_reg != '0) ? left_reg - 1'b1 : left_reg;

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        emit       = 1'b0;
        kind       = slfe_pkg::KIND_DATA;
        obyte      = 8'd0;
        olast      = 1'b0;
        if (take)
        begin
            case (phase_reg)
                slfe_pkg::PH_HUNT2:
                begin
                    phase_next = (item.data == slfe_pkg::SYNC_BYTE) ?
                                 slfe_pkg::PH_LEN : slfe_pkg::PH_HUNT1;
                    acc_next   = '0;
                    cnt_next   = 2'd0;
                end
                slfe_pkg::PH_LEN:
                begin
                    acc_next = acc_new;
                    if (cnt_reg != slfe_pkg::LAST_LEN_BYTE)
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                    else
                    begin
                        cnt_next = 2'd0;
                        if (acc_new > limit)
                        begin
                            phase_next = slfe_pkg::PH_HUNT1;
                            emit       = 1'b1;
                            kind       = slfe_pkg::KIND_REJECT;
                            olast      = 1'b1;
                        end
                        else if (acc_new == '0)
                        begin
                            phase_next = slfe_pkg::PH_HUNT1;
                            emit       = 1'b1;
                            kind       = slfe_pkg::KIND_EMPTY;
                            olast      = 1'b1;
                        end
                        else
                        begin
                            left_next  = acc_new[LEN_WIDTH-1:0];
                            phase_next = slfe_pkg::PH_DATA;
                        end
                    end
                end
                slfe_pkg::PH_DATA:
                begin
                    left_next = left_dec;
                    emit      = 1'b1;
                    kind      = slfe_pkg::KIND_DATA;
                    obyte     = item.data;
                    olast     = (left_dec == '0);
                    if (left_dec == '0)
                    begin
                        phase_next = slfe_pkg::PH_HUNT1;
                    end
                end
                default:
                begin
                    phase_next = (item.data == slfe_pkg::SYNC_BYTE) ?
                                 slfe_pkg::PH_HUNT2 : slfe_pkg::PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= slfe_pkg::PH_HUNT1;
            acc_reg       <= '0;
            cnt_reg       <= 2'd0;
            left_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_kind_reg <= kind;
            res_byte_reg <= obyte;
            res_last_reg <= olast;
        end
    end

    assign result.valid    = res_valid_reg;
    assign result.out_kind = res_kind_reg;
    assign result.out_byte = res_byte_reg;
    assign result.out_last = res_last_reg;

endmodule

FILE: hw/rtl/sync_length_frame_extractor.sv
// ----------------------------------------------------------------------------
// sync_length_frame_extractor: sync-word, length-prefixed deframer
// Strips a 0x5E 0x5E sync pair and a 4-byte little-endian length, then
// passes the payload bytes; reports empty frames and rejected lengths.
//
//   channel   dir   handshake      payload
//   stream    in    valid/ready    in_byte
//   result    out   valid/ready    out_kind, out_byte, out_last
//   cfg       in    cfg_we         cfg_wdata (max_len)
//
// One item per cycle sustained while result.ready holds; an item passes
// the input register and then the result register, from which it leaves.
// Throughput is set by the framing core, which updates its state per byte.
// Reset clears phase, length gathering and both valid flags; max_len
// returns to 1024. A stalled result holds while the input register still
// takes a byte; further bytes wait only when both registers are full.
// ----------------------------------------------------------------------------
module sync_length_frame_extractor
#(
    parameter int unsigned LEN_WIDTH = slfe_pkg::LEN_WIDTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    slfe_byte_if.sink                           stream,
    slfe_result_if.source                       result,
    input  logic                                cfg_we,
    input  logic [slfe_pkg::MAX_LEN_WIDTH-1:0]  cfg_wdata
);

    logic [slfe_pkg::MAX_LEN_WIDTH-1:0] max_len_reg;
    slfe_pkg::item_t                    item;
    logic                               take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= slfe_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    slfe_in_stage u_in_stage
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .take   (take),
        .item   (item)
    );

    slfe_core
    #(
        .LEN_WIDTH (LEN_WIDTH)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .max_len (max_len_reg),
        .take    (take),
        .result  (result)
    );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sync/length frame extractor
// Sends received bytes through the stream channel with random gaps and
// back-pressure, tracks the framing state in a local copy and checks every
// result item against the oldest expected one. Covers sync hunting, empty,
// rejected and accepted frames, and several length limits up to the largest.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        slfe_pkg::kind_t kind;
        logic [7:0]      data;
        logic            last;
    } frame_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [slfe_pkg::MAX_LEN_WIDTH-1:0] cfg_wdata;

    slfe_byte_if   stream_if ();
    slfe_result_if result_if ();

    sync_length_frame_extractor dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    frame_result_t pending_results[$];
    int unsigned   mismatches;
    bit            steady_flow;

    slfe_pkg::phase_t                       frame_phase;
    logic [slfe_pkg::ACC_WIDTH-1:0]         len_acc;
    logic [1:0]                             len_count;
    logic [slfe_pkg::LEN_WIDTH_DEFAULT-1:0] bytes_left;
    logic [slfe_pkg::MAX_LEN_WIDTH-1:0]     max_len;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL sync_length_frame_extractor");
        $finish;
    end

    function automatic void push_result(slfe_pkg::kind_t kind, logic [7:0] data, logic last);
        frame_result_t r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void track_byte(logic [7:0] b);
        case (frame_phase)
            slfe_pkg::PH_HUNT2:
            begin
                frame_phase = (b == slfe_pkg::SYNC_BYTE) ? slfe_pkg::PH_LEN : slfe_pkg::PH_HUNT1;
                len_acc     = '0;
                len_count   = '0;
            end
            slfe_pkg::PH_LEN:
            begin
                len_acc = len_acc | (slfe_pkg::ACC_WIDTH'(b) << (8 * len_count));
                if (len_count != slfe_pkg::LAST_LEN_BYTE)
                begin
                    len_count = len_count + 2'd1;
                end
                else
                begin
                    len_count = '0;
                    if (len_acc > slfe_pkg::ACC_WIDTH'(max_len))
                    begin
                        frame_phase = slfe_pkg::PH_HUNT1;
                        push_result(slfe_pkg::KIND_REJECT, 8'h00, 1'b1);
                    end
                    else if (len_acc == '0)
                    begin
                        frame_phase = slfe_pkg::PH_HUNT1;
                        push_result(slfe_pkg::KIND_EMPTY, 8'h00, 1'b1);
                    end
                    else
                    begin
                        bytes_left  = len_acc[slfe_pkg::LEN_WIDTH_DEFAULT-1:0];
                        frame_phase = slfe_pkg::PH_DATA;
                    end
                end
            end
            slfe_pkg::PH_DATA:
            begin
                if (bytes_left != '0)
                begin
                    bytes_left = bytes_left - 1'b1;
                end
                if (bytes_left == '0)
                begin
                    frame_phase = slfe_pkg::PH_HUNT1;
                end
                push_result(slfe_pkg::KIND_DATA, b, bytes_left == '0);
            end
            default:
            begin
                frame_phase = (b == slfe_pkg::SYNC_BYTE) ? slfe_pkg::PH_HUNT2 : slfe_pkg::PH_HUNT1;
            end
        endcase
    endfunction

    // check each result item, then drive ready for the next edge
    initial
    begin
        frame_result_t exp_r;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result kind=%0d byte=%02h last=%0b", $time,
                             result_if.out_kind, result_if.out_byte, result_if.out_last);
                end
                else
                begin
                    exp_r = pending_results[0];
                    pending_results.delete(0);
                    if (result_if.out_kind !== exp_r.kind)
                    begin
                        mismatches++;
                        $display("%0t: out_kind expected %0d actual %0d", $time,
                                 exp_r.kind, result_if.out_kind);
                    end
                    if (result_if.out_byte !== exp_r.data)
                    begin
                        mismatches++;
                        $display("%0t: out_byte expected %02h actual %02h", $time,
                                 exp_r.data, result_if.out_byte);
                    end
                    if (result_if.out_last !== exp_r.last)
                    begin
                        mismatches++;
                        $display("%0t: out_last expected %0b actual %0b", $time,
                                 exp_r.last, result_if.out_last);
                    end
                end
            end
            result_if.ready <= steady_flow || ($urandom_range(99) >= 11);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady_flow && $urandom_range(99) < 11)
        begin
            stream_if.valid <= 1'b0;
            @(posedge clk);
        end
        stream_if.valid   <= 1'b1;
        stream_if.in_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!stream_if.ready);
        track_byte(b);
    endtask

    // hold the stream until every expected result is out and the pipeline is empty
    task automatic settle_stream();
        stream_if.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [slfe_pkg::MAX_LEN_WIDTH-1:0] value);
        settle_stream();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        max_len  = value;
    endtask

    task automatic send_frame(input logic [31:0] len);
        int unsigned n;
        n = (len != 0 && len <= slfe_pkg::ACC_WIDTH'(max_len)) ? len : 0;
        send_byte(slfe_pkg::SYNC_BYTE);
        send_byte(slfe_pkg::SYNC_BYTE);
        for (int i = 0; i < 4; i++)
        begin
            send_byte(len[8*i +: 8]);
        end
        repeat (n) send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_noise();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == slfe_pkg::SYNC_BYTE)
        begin
            b = ~b;
        end
        if ($urandom_range(3) == 0)
        begin
            send_byte(slfe_pkg::SYNC_BYTE);
        end
        send_byte(b);
    endtask

    function automatic logic [31:0] pick_length();
        int unsigned r;
        int unsigned cap;
        r   = $urandom_range(99);
        cap = (max_len < 24) ? max_len : 24;
        if (r < 10)
            return 0;
        else if (r < 72)
            return (cap == 0) ? 1 : $urandom_range(cap, 1);
        else if (r < 82)
            return max_len + 1;
        else if (r < 90)
            return {1'b1, 31'($urandom)};
        else
            return max_len + $urandom_range(300, 1);
    endfunction

    task automatic test_directed();
        logic [7:0] seq[$];
        seq = '{8'hA1, slfe_pkg::SYNC_BYTE, 8'h12,
                slfe_pkg::SYNC_BYTE, slfe_pkg::SYNC_BYTE, 8'h02, 8'h00, 8'h00, 8'h00,
                8'h00, 8'hFF,
                slfe_pkg::SYNC_BYTE, slfe_pkg::SYNC_BYTE, 8'h00, 8'h00, 8'h00, 8'h00,
                slfe_pkg::SYNC_BYTE, slfe_pkg::SYNC_BYTE, 8'h00, 8'h00, 8'h00, 8'h80};
        foreach (seq[i])
        begin
            send_byte(seq[i]);
        end
    endtask

    task automatic test_length_limits();
        write_max_len(13'd0);
        send_frame(32'd1);
        send_frame(32'd0);
        write_max_len(13'd8191);
        send_frame(32'd20);
        send_frame(32'd8192);
        write_max_len(13'd5);
        send_frame(32'd5);
        send_frame(32'd6);
        send_frame(32'h0100_0005);
        send_frame(32'hFFFF_FFFF);
    endtask

    task automatic run_random_phase(input logic [slfe_pkg::MAX_LEN_WIDTH-1:0] limit,
                                    input bit steady, input int unsigned quota);
        int unsigned sent;
        logic [31:0] len;
        write_max_len(limit);
        steady_flow = steady;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(99) < 20)
            begin
                send_noise();
            end
            else
            begin
                len  = pick_length();
                sent += 6 + ((len != 0 && len <= slfe_pkg::ACC_WIDTH'(max_len)) ? len : 0);
                send_frame(len);
            end
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(13'd1024, 1'b0, 90);
        run_random_phase(13'd12, 1'b0, 90);
        run_random_phase(13'd1, 1'b0, 70);
        run_random_phase(13'd8191, 1'b1, 100);
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        stream_if.valid   <= 1'b0;
        stream_if.in_byte <= 8'h00;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        mismatches  = 0;
        steady_flow = 1'b0;
        frame_phase = slfe_pkg::PH_HUNT1;
        len_acc     = '0;
        len_count   = '0;
        bytes_left  = '0;
        max_len     = slfe_pkg::MAX_LEN_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_length_limits();
        test_random_traffic();

        settle_stream();
        if (mismatches == 0)
        begin
            $display("PASS sync_length_frame_extractor");
        end
        else
        begin
            $display("FAIL sync_length_frame_extractor");
        end
        $finish;
    end

endmodule
